@@ src/sssp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sssp_pkg;
	localparam int MAX_NODES = 32;
	localparam int COST_BITS = 16;
	localparam int LINK_ID_BITS = 8;
	localparam logic [1:0] CMD_CLEAR   = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_COMPUTE = 2'd2;
	localparam logic [1:0] CMD_NONE    = 2'd3;
	localparam int IN_BITS = 40;
	localparam int OUT_BITS = 40;

	typedef struct packed {
		logic [1:0]  command;
		logic [4:0]  from_node;
		logic [4:0]  to_node;
		logic [15:0] link_cost;
		logic [7:0]  link_id;
	} cmd_t;
endpackage
`default_nettype wire

@@ src/sssp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Input side: two-entry command queue decoupling acceptance from the engine.
module sssp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire sssp_pkg::cmd_t    in_cmd,
	output logic                   q_valid,
	input  wire logic              q_pop,
	output sssp_pkg::cmd_t         q_cmd
);
	import sssp_pkg::*;
	cmd_t   mem_q [2];
	logic   wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;

	// Command 3 is dropped at the door.
	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready && (in_cmd.command != CMD_NONE);
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_cmd;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

@@ src/sssp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Engine: matrix memories, clear sweep, Dijkstra sequencer, result register.
module sssp_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	output logic                 q_pop,
	input  wire sssp_pkg::cmd_t  q_cmd,
	input  wire logic [5:0]      node_count,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [4:0]           o_dest,
	output logic                 o_reach,
	output logic [4:0]           o_hop,
	output logic [7:0]           o_link,
	output logic [15:0]          o_cost,
	output logic                 o_last
);
	import sssp_pkg::*;
	localparam int NB = $clog2(MAX_NODES);
	localparam int AB = 2 * NB;
	localparam int DEPTH = MAX_NODES * MAX_NODES;
	localparam logic [COST_BITS-1:0] INF = {COST_BITS{1'b1}};

	localparam logic [3:0] ST_IDLE = 4'd0, ST_CLR = 4'd1, ST_INIT = 4'd2,
		ST_INITW = 4'd3, ST_SCAN = 4'd4, ST_SCANW = 4'd5, ST_RELAX = 4'd6,
		ST_RELW = 4'd7, ST_EMIT = 4'd8, ST_NEXT = 4'd9;

	logic [3:0] st_q;
	logic [COST_BITS-1:0] cost_mem [DEPTH];
	logic [LINK_ID_BITS-1:0] link_mem [DEPTH];
	logic [COST_BITS-1:0] dist_q [MAX_NODES];
	logic [NB-1:0] hop_q [MAX_NODES];
	logic [LINK_ID_BITS-1:0] hl_q [MAX_NODES];
	logic [MAX_NODES-1:0] settled_q;
	logic [AB-1:0] clr_q;
	logic [NB:0] n_q, idx_q, round_q;
	logic [NB-1:0] src_q, pick_q, ridx_q;
	logic [COST_BITS-1:0] best_q;
	logic found_q, srcok_q;
	logic [COST_BITS-1:0] rd_cost_q;
	logic [LINK_ID_BITS-1:0] rd_link_q;
	logic [AB-1:0] raddr;
	logic [5:0] ncl;
	logic [NB:0] nact;
	logic [COST_BITS:0] sum;
	logic [COST_BITS-1:0] satsum;

	always_comb begin
		ncl = (node_count == 6'd0) ? 6'd1 : node_count;
		if ({{(NB+1){1'b0}}, ncl} > (NB+7)'(MAX_NODES)) nact = (NB+1)'(MAX_NODES);
		else nact = (NB+1)'(ncl);
	end

	// Read address: row is source during init, picked node during relax.
	always_comb begin
		if (st_q == ST_INIT) raddr = {src_q, idx_q[NB-1:0]};
		else raddr = {pick_q, idx_q[NB-1:0]};
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_CLR) cost_mem[clr_q] <= INF;
		else if (st_q == ST_IDLE && q_valid && q_cmd.command == CMD_WRITE) begin
			cost_mem[{q_cmd.from_node[NB-1:0], q_cmd.to_node[NB-1:0]}] <=
				COST_BITS'(q_cmd.link_cost);
			link_mem[{q_cmd.from_node[NB-1:0], q_cmd.to_node[NB-1:0]}] <=
				LINK_ID_BITS'(q_cmd.link_id);
		end
		rd_cost_q <= cost_mem[raddr];
		rd_link_q <= link_mem[raddr];
	end

	assign sum = {1'b0, dist_q[pick_q]} + {1'b0, rd_cost_q};
	assign satsum = (sum >= {1'b0, INF}) ? INF : sum[COST_BITS-1:0];
	assign q_pop = (st_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR; clr_q <= '0; settled_q <= '0; out_valid <= 1'b0;
			n_q <= '0; idx_q <= '0; round_q <= '0; src_q <= '0; pick_q <= '0;
			ridx_q <= '0; best_q <= '0; found_q <= 1'b0; srcok_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: if (q_valid) begin
					case (q_cmd.command)
						CMD_CLEAR: begin clr_q <= '0; st_q <= ST_CLR; end
						CMD_COMPUTE: begin
							n_q <= nact; idx_q <= '0;
							src_q <= q_cmd.from_node[NB-1:0];
							srcok_q <= ({{(NB-4){1'b0}}, q_cmd.from_node} < nact);
							settled_q <= '0;
							st_q <= ({{(NB-4){1'b0}}, q_cmd.from_node} < nact)
								? ST_INIT : ST_EMIT;
						end
						default: st_q <= ST_IDLE;
					endcase
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AB'(DEPTH - 1)) st_q <= ST_IDLE;
				end
				ST_INIT: begin ridx_q <= idx_q[NB-1:0]; st_q <= ST_INITW; end
				ST_INITW: begin
					dist_q[ridx_q] <= (ridx_q == src_q) ? '0 : rd_cost_q;
					hop_q[ridx_q] <= ridx_q;
					hl_q[ridx_q] <= rd_link_q;
					if (ridx_q == src_q) settled_q[ridx_q] <= 1'b1;
					if (idx_q + 1'b1 == n_q) begin
						round_q <= (NB+1)'(1); idx_q <= '0; best_q <= INF;
						found_q <= 1'b0;
						st_q <= (n_q == (NB+1)'(1)) ? ST_EMIT : ST_SCAN;
					end else begin
						idx_q <= idx_q + 1'b1; st_q <= ST_INIT;
					end
				end
				ST_SCAN: begin
					if (!settled_q[idx_q[NB-1:0]] && dist_q[idx_q[NB-1:0]] < best_q) begin
						best_q <= dist_q[idx_q[NB-1:0]]; pick_q <= idx_q[NB-1:0];
						found_q <= 1'b1;
					end
					if (idx_q + 1'b1 == n_q) st_q <= ST_SCANW;
					else idx_q <= idx_q + 1'b1;
				end
				ST_SCANW: begin
					idx_q <= '0;
					if (!found_q) st_q <= ST_EMIT;
					else begin settled_q[pick_q] <= 1'b1; st_q <= ST_RELAX; end
				end
				ST_RELAX: begin ridx_q <= idx_q[NB-1:0]; st_q <= ST_RELW; end
				ST_RELW: begin
					if (!settled_q[ridx_q] && satsum < dist_q[ridx_q]) begin
						dist_q[ridx_q] <= satsum;
						hop_q[ridx_q] <= hop_q[pick_q];
						hl_q[ridx_q] <= hl_q[pick_q];
					end
					if (idx_q + 1'b1 == n_q) begin
						idx_q <= '0;
						if (round_q + 1'b1 == n_q) st_q <= ST_EMIT;
						else begin
							round_q <= round_q + 1'b1; best_q <= INF;
							found_q <= 1'b0; st_q <= ST_SCAN;
						end
					end else begin
						idx_q <= idx_q + 1'b1; st_q <= ST_RELAX;
					end
				end
				ST_EMIT: if (!out_valid || out_ready) begin
					out_valid <= 1'b1;
					o_dest <= 5'(idx_q);
					o_last <= (idx_q + 1'b1 == n_q);
					if (!srcok_q) begin
						o_reach <= 1'b0; o_hop <= '0; o_link <= '0; o_cost <= 16'hFFFF;
					end else if (idx_q[NB-1:0] == src_q) begin
						o_reach <= 1'b1; o_hop <= 5'(src_q); o_link <= '0; o_cost <= '0;
					end else if (dist_q[idx_q[NB-1:0]] != INF) begin
						o_reach <= 1'b1; o_hop <= 5'(hop_q[idx_q[NB-1:0]]);
						o_link <= 8'(hl_q[idx_q[NB-1:0]]);
						o_cost <= 16'(dist_q[idx_q[NB-1:0]]);
					end else begin
						o_reach <= 1'b0; o_hop <= '0; o_link <= '0; o_cost <= 16'hFFFF;
					end
					if (idx_q + 1'b1 == n_q) st_q <= ST_NEXT;
					else idx_q <= idx_q + 1'b1;
				end
				ST_NEXT: if (out_ready) begin
					out_valid <= 1'b0; st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
			if (st_q != ST_EMIT && st_q != ST_NEXT && out_valid && out_ready)
				out_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

@@ src/single_source_shortest_path.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Clear: a sweep of all MAX_NODES^2 entries of the cost memory. Compute: an init
// pass over the source row, then per round a scan for the nearest unsettled node and
// a relax pass over its row (n = active nodes), then n results, one result per cycle
// while m_axis_tready is high. Reset: asynchronous arst_n; after reset a clearing pass
// sets all costs to infinity; commands queue meanwhile. node_count resets to 32.
module single_source_shortest_path (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [5:0]  cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// command[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	// from_node[4:0], to_node[9:5], link_cost[25:10], link_id[33:26]
	input  wire logic [sssp_pkg::IN_BITS-1:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// dest_node[4:0], reachable[5], first_node[10:6], first_link[18:11], path_cost[34:19]
	output logic [sssp_pkg::OUT_BITS-1:0] m_axis_tdata,
	output logic             m_axis_tlast
);
	import sssp_pkg::*;
	logic [5:0] node_count_q;
	cmd_t in_cmd, q_cmd;
	logic q_valid, q_pop;
	logic [4:0] o_dest, o_hop;
	logic o_reach;
	logic [7:0] o_link;
	logic [15:0] o_cost;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) node_count_q <= 6'd32;
		else if (cfg_we) node_count_q <= cfg_wdata;
	end

	assign in_cmd = '{command: s_axis_tuser, from_node: s_axis_tdata[4:0],
		to_node: s_axis_tdata[9:5], link_cost: s_axis_tdata[25:10],
		link_id: s_axis_tdata[33:26]};

	sssp_front u_front (.clk, .arst_n, .in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready), .in_cmd, .q_valid, .q_pop, .q_cmd);

	sssp_back u_back (.clk, .arst_n, .q_valid, .q_pop,
		.q_cmd, .node_count(node_count_q), .out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready), .o_dest, .o_reach, .o_hop, .o_link, .o_cost,
		.o_last(m_axis_tlast));

	assign m_axis_tdata = {5'd0, o_cost, o_link, o_hop, o_reach, o_dest};

	// Unreachable result carries infinite cost.
	a_unreach: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[5] |-> m_axis_tdata[34:19] == 16'hFFFF)
		else $error("unreachable result with finite cost");
	// Result held while stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed under stall");
endmodule
`default_nettype wire
